// ===== sv/ssc_pkg.sv =====
// Shared constants for the sprite scale compositor: field widths, register
// indexes, reset values and the scaling ratio.
// No dependencies; every other file of the block uses this package.
package ssc_pkg;

   // Default geometry, used as defaults of the top-level parameters.
   localparam int SCREEN_WIDTH  = 512;
   localparam int SCREEN_HEIGHT = 512;
   localparam int SPRITE_WIDTH  = 128;
   localparam int SPRITE_HEIGHT = 128;

   // Scaling ratio 150/100, used for the box size.
   localparam int SCALE_NUM = 150;
   localparam int SCALE_DEN = 100;

   // Fixed field widths.
   localparam int PIXEL_W    = 9;
   localparam int ADDR_W     = 14;
   localparam int COLOR_W    = 16;
   localparam int CENTER_W   = 12;
   localparam int FRAME_W    = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Store depth follows from the address width.
   localparam int STORE_DEPTH = 1 << ADDR_W;

   // Item modes.
   localparam logic MODE_WRITE  = 1'b0;
   localparam logic MODE_RENDER = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_X     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_Y     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BACKGROUND   = 3'd4;

   // Reset values of the configuration registers.
   localparam logic signed [CENTER_W-1:0] CENTER_RESET = 12'sd256;
   localparam logic [FRAME_W-1:0]         FRAME_RESET  = 8'd128;
   localparam logic [COLOR_W-1:0]         BACKGROUND_RESET = 16'h0923;

endpackage

// ===== sv/ssc_if.sv =====
// Channel interfaces of the sprite scale compositor: request, response
// and configuration write channels, each with valid/ready handshake.
// Depends on ssc_pkg for the field widths.

interface ssc_req_if;
   logic                             valid;
   logic                             ready;
   logic                             mode;
   logic [ssc_pkg::PIXEL_W-1:0]      pixel_x;
   logic [ssc_pkg::PIXEL_W-1:0]      pixel_y;
   logic [ssc_pkg::ADDR_W-1:0]       sprite_addr;
   logic [ssc_pkg::COLOR_W-1:0]      sprite_value;

   modport source (output valid, mode, pixel_x, pixel_y, sprite_addr, sprite_value,
                   input ready);
   modport sink   (input valid, mode, pixel_x, pixel_y, sprite_addr, sprite_value,
                   output ready);
endinterface

interface ssc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [ssc_pkg::COLOR_W-1:0]      screen_pixel;
   logic                             inside_box;

   modport source (output valid, screen_pixel, inside_box, input ready);
   modport sink   (input valid, screen_pixel, inside_box, output ready);
endinterface

interface ssc_csr_if;
   logic                             valid;
   logic                             ready;
   logic [ssc_pkg::CSR_IDX_W-1:0]    index;
   logic [ssc_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/sprite_scale_compositor_core.sv =====
// Sprite scale compositor core: four-stage pipeline around one sprite store.
// Depends on ssc_pkg and on the channel interfaces in ssc_if.sv.
//
//   Channel  Direction  Handshake      Carries
//   req_ch   in         valid/ready    mode, pixel_x, pixel_y, sprite_addr, sprite_value
//   rsp_ch   out        valid/ready    screen_pixel, inside_box (render items only)
//   csr_ch   in         valid/ready    register index, write data (always ready)
//
// One item per clock is accepted unless a stalled response has backed up every
// stage. The request transaction loads the offset stage, and the source index,
// store address and registered store read stages follow; the last of these offers
// the render result. Reset loads the register defaults and empties the pipeline;
// the store is not cleared. A stalled response holds the output stage and backs up
// the stages behind it; req_ch.ready drops only when every stage is occupied.
module sprite_scale_compositor_core #(
   parameter int SCREEN_WIDTH  = ssc_pkg::SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = ssc_pkg::SCREEN_HEIGHT,
   parameter int SPRITE_WIDTH  = ssc_pkg::SPRITE_WIDTH,
   parameter int SPRITE_HEIGHT = ssc_pkg::SPRITE_HEIGHT
) (
   input  logic        clock,
   input  logic        reset,
   ssc_req_if.sink     req_ch,
   ssc_rsp_if.source   rsp_ch,
   ssc_csr_if.sink     csr_ch
);

   // Scaled box size, rounded to nearest, and its half.
   localparam int DRAW_W = (SPRITE_WIDTH * ssc_pkg::SCALE_NUM + ssc_pkg::SCALE_DEN / 2)
                           / ssc_pkg::SCALE_DEN;
   localparam int DRAW_H = (SPRITE_HEIGHT * ssc_pkg::SCALE_NUM + ssc_pkg::SCALE_DEN / 2)
                           / ssc_pkg::SCALE_DEN;
   localparam int HALF_W = DRAW_W / 2;
   localparam int HALF_H = DRAW_H / 2;

   // Signed width for centers, box origins and raw offsets.
   localparam int SCREEN_MAX = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
   localparam int DRAW_MAX   = (DRAW_W > DRAW_H) ? DRAW_W : DRAW_H;
   localparam int MAG        = (1 << (ssc_pkg::CENTER_W - 1)) + SCREEN_MAX + DRAW_MAX
                               + (1 << ssc_pkg::PIXEL_W);
   localparam int POS_W      = $clog2(MAG) + 1;

   // Offset inside the box and the reciprocal used for floor(2*d/3).
   localparam int OFF_W  = $clog2(DRAW_MAX);
   localparam int RSH    = OFF_W + 3;
   localparam int PROD_W = OFF_W + 1 + RSH;
   localparam logic [RSH-1:0] RECIP3 = RSH'(((1 << RSH) + 2) / 3);

   // Widths for the frame compare and the linear address.
   localparam int CMP_W = (OFF_W > ssc_pkg::FRAME_W) ? OFF_W : ssc_pkg::FRAME_W;
   localparam int LIN_W = (OFF_W + ssc_pkg::FRAME_W + 1 > ssc_pkg::ADDR_W)
                          ? OFF_W + ssc_pkg::FRAME_W + 1 : ssc_pkg::ADDR_W;

   localparam logic signed [POS_W-1:0] DRAW_W_S = POS_W'(DRAW_W);
   localparam logic signed [POS_W-1:0] DRAW_H_S = POS_W'(DRAW_H);

   // Clamp a requested center into the screen and return the box origin.
   // The lower bound is checked first, so it wins when the bounds cross.
   function automatic logic signed [POS_W-1:0] box_origin(
      input logic signed [ssc_pkg::CENTER_W-1:0] center,
      input int half,
      input int screen
   );
      logic signed [POS_W-1:0] c;
      logic signed [POS_W-1:0] lo;
      logic signed [POS_W-1:0] hi;
      logic signed [POS_W-1:0] v;
      c  = POS_W'(center);
      lo = POS_W'(half);
      hi = POS_W'(screen - half);
      if (c < lo) begin
         v = lo;
      end else if (c > hi) begin
         v = hi;
      end else begin
         v = c;
      end
      return v - lo;
   endfunction

   // Configuration state. Centers are kept as clamped box origins.
   logic signed [POS_W-1:0]          origin_x_ff, origin_x_in;
   logic signed [POS_W-1:0]          origin_y_ff, origin_y_in;
   logic [ssc_pkg::FRAME_W-1:0]      frame_width_ff, frame_width_in;
   logic [ssc_pkg::FRAME_W-1:0]      frame_height_ff, frame_height_in;
   logic [ssc_pkg::COLOR_W-1:0]      background_ff, background_in;

   // Pipeline control.
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s3_valid_ff, s3_valid_in;
   logic s4_valid_ff, s4_valid_in;
   logic en1, en2, en3, en4;

   // Stage 1: box offsets and hit test.
   logic                             s1_mode_ff, s1_mode_in;
   logic [OFF_W-1:0]                 s1_dx_ff, s1_dx_in;
   logic [OFF_W-1:0]                 s1_dy_ff, s1_dy_in;
   logic                             s1_inside_ff, s1_inside_in;
   logic [ssc_pkg::ADDR_W-1:0]       s1_addr_ff, s1_addr_in;
   logic [ssc_pkg::COLOR_W-1:0]      s1_value_ff, s1_value_in;

   // Stage 2: source column and row.
   logic                             s2_mode_ff, s2_mode_in;
   logic [OFF_W-1:0]                 s2_sx_ff, s2_sx_in;
   logic [OFF_W-1:0]                 s2_sy_ff, s2_sy_in;
   logic                             s2_inside_ff, s2_inside_in;
   logic [ssc_pkg::ADDR_W-1:0]       s2_addr_ff, s2_addr_in;
   logic [ssc_pkg::COLOR_W-1:0]      s2_value_ff, s2_value_in;

   // Stage 3: store address and sprite select.
   logic                             s3_mode_ff, s3_mode_in;
   logic                             s3_use_ff, s3_use_in;
   logic                             s3_inside_ff, s3_inside_in;
   logic [ssc_pkg::ADDR_W-1:0]       s3_addr_ff, s3_addr_in;
   logic [ssc_pkg::COLOR_W-1:0]      s3_value_ff, s3_value_in;

   // Stage 4: output register with the store read data.
   logic                             s4_use_ff, s4_use_in;
   logic                             s4_inside_ff, s4_inside_in;
   logic [ssc_pkg::COLOR_W-1:0]      mem_q_ff;
   logic                             mem_we, mem_re;
   logic [ssc_pkg::COLOR_W-1:0]      sprite_mem [ssc_pkg::STORE_DEPTH];

   // Combinational helpers.
   logic signed [POS_W-1:0]          px_ext, py_ext, dx_full, dy_full;
   logic [PROD_W-1:0]                prod_x, prod_y;
   logic [CMP_W-1:0]                 sx_cmp, sy_cmp, fw_cmp, fh_cmp;
   logic [LIN_W-1:0]                 lin_addr;
   logic [ssc_pkg::COLOR_W-1:0]      out_pixel;

   // Stage enables: a stage moves when the one after it is free or moving.
   assign en4 = !s4_valid_ff || rsp_ch.ready;
   assign en3 = !s3_valid_ff || en4;
   assign en2 = !s2_valid_ff || en3;
   assign en1 = !s1_valid_ff || en2;

   assign req_ch.ready = en1;
   assign csr_ch.ready = 1'b1;

   // Configuration writes.
   always_comb begin
      origin_x_in     = origin_x_ff;
      origin_y_in     = origin_y_ff;
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      background_in   = background_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            ssc_pkg::REG_CENTER_X: begin
               origin_x_in = box_origin($signed(csr_ch.data[ssc_pkg::CENTER_W-1:0]),
                                        HALF_W, SCREEN_WIDTH);
            end
            ssc_pkg::REG_CENTER_Y: begin
               origin_y_in = box_origin($signed(csr_ch.data[ssc_pkg::CENTER_W-1:0]),
                                        HALF_H, SCREEN_HEIGHT);
            end
            ssc_pkg::REG_FRAME_WIDTH: begin
               frame_width_in = csr_ch.data[ssc_pkg::FRAME_W-1:0];
            end
            ssc_pkg::REG_FRAME_HEIGHT: begin
               frame_height_in = csr_ch.data[ssc_pkg::FRAME_W-1:0];
            end
            ssc_pkg::REG_BACKGROUND: begin
               background_in = csr_ch.data[ssc_pkg::COLOR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Stage 1: offsets from the box origin and the hit test.
   always_comb begin
      px_ext  = $signed({{(POS_W - ssc_pkg::PIXEL_W){1'b0}}, req_ch.pixel_x});
      py_ext  = $signed({{(POS_W - ssc_pkg::PIXEL_W){1'b0}}, req_ch.pixel_y});
      dx_full = px_ext - origin_x_ff;
      dy_full = py_ext - origin_y_ff;
      s1_valid_in  = en1 ? (req_ch.valid && req_ch.ready) : s1_valid_ff;
      s1_mode_in   = en1 ? req_ch.mode : s1_mode_ff;
      s1_dx_in     = en1 ? dx_full[OFF_W-1:0] : s1_dx_ff;
      s1_dy_in     = en1 ? dy_full[OFF_W-1:0] : s1_dy_ff;
      s1_inside_in = en1 ? (!dx_full[POS_W-1] && (dx_full < DRAW_W_S) &&
                            !dy_full[POS_W-1] && (dy_full < DRAW_H_S)) : s1_inside_ff;
      s1_addr_in   = en1 ? req_ch.sprite_addr : s1_addr_ff;
      s1_value_in  = en1 ? req_ch.sprite_value : s1_value_ff;
   end

   // Stage 2: source index floor(2*d/3) by reciprocal multiply.
   always_comb begin
      prod_x = PROD_W'({s1_dx_ff, 1'b0}) * PROD_W'(RECIP3);
      prod_y = PROD_W'({s1_dy_ff, 1'b0}) * PROD_W'(RECIP3);
      s2_valid_in  = en2 ? s1_valid_ff : s2_valid_ff;
      s2_mode_in   = en2 ? s1_mode_ff : s2_mode_ff;
      s2_sx_in     = en2 ? prod_x[RSH +: OFF_W] : s2_sx_ff;
      s2_sy_in     = en2 ? prod_y[RSH +: OFF_W] : s2_sy_ff;
      s2_inside_in = en2 ? s1_inside_ff : s2_inside_ff;
      s2_addr_in   = en2 ? s1_addr_ff : s2_addr_ff;
      s2_value_in  = en2 ? s1_value_ff : s2_value_ff;
   end

   // Stage 3: frame test and linear store address; writes keep their address.
   always_comb begin
      sx_cmp   = CMP_W'(s2_sx_ff);
      sy_cmp   = CMP_W'(s2_sy_ff);
      fw_cmp   = CMP_W'(frame_width_ff);
      fh_cmp   = CMP_W'(frame_height_ff);
      lin_addr = LIN_W'(s2_sy_ff) * LIN_W'(frame_width_ff) + LIN_W'(s2_sx_ff);
      s3_valid_in  = en3 ? s2_valid_ff : s3_valid_ff;
      s3_mode_in   = en3 ? s2_mode_ff : s3_mode_ff;
      s3_use_in    = en3 ? (s2_inside_ff && (sx_cmp < fw_cmp) && (sy_cmp < fh_cmp))
                         : s3_use_ff;
      s3_inside_in = en3 ? s2_inside_ff : s3_inside_ff;
      s3_value_in  = en3 ? s2_value_ff : s3_value_ff;
      if (!en3) begin
         s3_addr_in = s3_addr_ff;
      end else if (s2_mode_ff == ssc_pkg::MODE_WRITE) begin
         s3_addr_in = s2_addr_ff;
      end else begin
         s3_addr_in = lin_addr[ssc_pkg::ADDR_W-1:0];
      end
   end

   // Stage 4: every item passes the store in program order, one access a cycle unless the output is stalled.
   always_comb begin
      mem_we = s3_valid_ff && en4 && (s3_mode_ff == ssc_pkg::MODE_WRITE);
      mem_re = s3_valid_ff && en4 && (s3_mode_ff == ssc_pkg::MODE_RENDER);
      s4_valid_in  = en4 ? mem_re : s4_valid_ff;
      s4_use_in    = en4 ? s3_use_ff : s4_use_ff;
      s4_inside_in = en4 ? s3_inside_ff : s4_inside_ff;
   end

   // Sprite store: one write or one registered read per cycle while stage 4 moves.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         sprite_mem[s3_addr_ff] <= s3_value_ff;
      end
      if (mem_re) begin
         mem_q_ff <= sprite_mem[s3_addr_ff];
      end
   end

   // Control and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff     <= box_origin(ssc_pkg::CENTER_RESET, HALF_W, SCREEN_WIDTH);
         origin_y_ff     <= box_origin(ssc_pkg::CENTER_RESET, HALF_H, SCREEN_HEIGHT);
         frame_width_ff  <= ssc_pkg::FRAME_RESET;
         frame_height_ff <= ssc_pkg::FRAME_RESET;
         background_ff   <= ssc_pkg::BACKGROUND_RESET;
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
         s3_valid_ff     <= 1'b0;
         s4_valid_ff     <= 1'b0;
      end else begin
         origin_x_ff     <= origin_x_in;
         origin_y_ff     <= origin_y_in;
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         background_ff   <= background_in;
         s1_valid_ff     <= s1_valid_in;
         s2_valid_ff     <= s2_valid_in;
         s3_valid_ff     <= s3_valid_in;
         s4_valid_ff     <= s4_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s1_mode_ff   <= s1_mode_in;
      s1_dx_ff     <= s1_dx_in;
      s1_dy_ff     <= s1_dy_in;
      s1_inside_ff <= s1_inside_in;
      s1_addr_ff   <= s1_addr_in;
      s1_value_ff  <= s1_value_in;
      s2_mode_ff   <= s2_mode_in;
      s2_sx_ff     <= s2_sx_in;
      s2_sy_ff     <= s2_sy_in;
      s2_inside_ff <= s2_inside_in;
      s2_addr_ff   <= s2_addr_in;
      s2_value_ff  <= s2_value_in;
      s3_mode_ff   <= s3_mode_in;
      s3_use_ff    <= s3_use_in;
      s3_inside_ff <= s3_inside_in;
      s3_addr_ff   <= s3_addr_in;
      s3_value_ff  <= s3_value_in;
      s4_use_ff    <= s4_use_in;
      s4_inside_ff <= s4_inside_in;
   end

   // Response: sprite or background, bytes swapped.
   assign out_pixel           = s4_use_ff ? mem_q_ff : background_ff;
   assign rsp_ch.valid        = s4_valid_ff;
   assign rsp_ch.screen_pixel = {out_pixel[7:0], out_pixel[15:8]};
   assign rsp_ch.inside_box   = s4_inside_ff;

endmodule

// ===== dv/sprite_pixel_checker.sv =====
// Checker for the sprite scale compositor: watches the request, response and
// register write channels, predicts each rendered pixel and compares it.
// Depends on ssc_pkg and on the channel interfaces in ssc_if.sv.
module sprite_pixel_checker
   import ssc_pkg::*;
(
   input  logic clock,
   input  logic reset,
   ssc_req_if   req_ch,
   ssc_rsp_if   rsp_ch,
   ssc_csr_if   csr_ch,
   output int   results_pending,
   output int   failures
);
   timeunit 1ns;
   timeprecision 1ps;

   // Size of the scaled box, rounded to the nearest pixel.
   localparam int DRAW_W = (SPRITE_WIDTH * SCALE_NUM + SCALE_DEN / 2) / SCALE_DEN;
   localparam int DRAW_H = (SPRITE_HEIGHT * SCALE_NUM + SCALE_DEN / 2) / SCALE_DEN;

   typedef struct packed {
      logic [COLOR_W-1:0] screen_pixel;
      logic               inside_box;
   } pixel_result_type;

   // Private copy of the sprite store and of the registers.
   logic [COLOR_W-1:0]         sprite_mem [STORE_DEPTH];
   logic signed [CENTER_W-1:0] center_x_q;
   logic signed [CENTER_W-1:0] center_y_q;
   logic [FRAME_W-1:0]         frame_w_q;
   logic [FRAME_W-1:0]         frame_h_q;
   logic [COLOR_W-1:0]         background_q;
   pixel_result_type           expected_pixels [$];
   int                         fail_count = 0;

   // Keep the box on screen; the lower bound wins if the bounds cross.
   function automatic int box_start(input int center, input int span, input int draw);
      int c;
      c = center;
      if (c < draw / 2) c = draw / 2;
      else if (c > span - draw / 2) c = span - draw / 2;
      return c - draw / 2;
   endfunction

   function automatic pixel_result_type predict_pixel(input logic [PIXEL_W-1:0] x,
                                                      input logic [PIXEL_W-1:0] y);
      int                 dx;
      int                 dy;
      int                 sx;
      int                 sy;
      logic [ADDR_W-1:0]  addr;
      logic [COLOR_W-1:0] color;
      pixel_result_type   r;
      dx = int'(x) - box_start(int'(center_x_q), SCREEN_WIDTH, DRAW_W);
      dy = int'(y) - box_start(int'(center_y_q), SCREEN_HEIGHT, DRAW_H);
      color = background_q;
      r.inside_box = (dx >= 0 && dx < DRAW_W && dy >= 0 && dy < DRAW_H);
      if (r.inside_box) begin
         // Nearest neighbour: box offset maps back to offset*100/150.
         sx = dx * SCALE_DEN / SCALE_NUM;
         sy = dy * SCALE_DEN / SCALE_NUM;
         if (sx < int'(frame_w_q) && sy < int'(frame_h_q)) begin
            addr = ADDR_W'(sy * int'(frame_w_q) + sx);
            color = sprite_mem[addr];
         end
      end
      r.screen_pixel = {color[7:0], color[15:8]};
      return r;
   endfunction

   // Responses are checked before new requests are predicted in the same cycle.
   always @(posedge clock) begin
      pixel_result_type want;
      if (reset) begin
         center_x_q   = CENTER_RESET;
         center_y_q   = CENTER_RESET;
         frame_w_q    = FRAME_RESET;
         frame_h_q    = FRAME_RESET;
         background_q = BACKGROUND_RESET;
         expected_pixels.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_pixels.size() == 0) begin
               fail_count++;
               $display("%0t: response transaction with none expected: actual pixel %h inside %b",
                        $time, rsp_ch.screen_pixel, rsp_ch.inside_box);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_ch.screen_pixel !== want.screen_pixel) begin
                  fail_count++;
                  $display("%0t: screen_pixel mismatch: expected %h, actual %h",
                           $time, want.screen_pixel, rsp_ch.screen_pixel);
               end
               if (rsp_ch.inside_box !== want.inside_box) begin
                  fail_count++;
                  $display("%0t: inside_box mismatch: expected %b, actual %b",
                           $time, want.inside_box, rsp_ch.inside_box);
               end
            end
         end

         // A write transaction updates the store; a render transaction queues a pixel.
         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.mode == MODE_WRITE)
               sprite_mem[req_ch.sprite_addr] = req_ch.sprite_value;
            else
               expected_pixels.push_back(predict_pixel(req_ch.pixel_x, req_ch.pixel_y));
         end

         // Register writes only arrive while the block is idle.
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               REG_CENTER_X:     center_x_q   = csr_ch.data[CENTER_W-1:0];
               REG_CENTER_Y:     center_y_q   = csr_ch.data[CENTER_W-1:0];
               REG_FRAME_WIDTH:  frame_w_q    = csr_ch.data[FRAME_W-1:0];
               REG_FRAME_HEIGHT: frame_h_q    = csr_ch.data[FRAME_W-1:0];
               REG_BACKGROUND:   background_q = csr_ch.data[COLOR_W-1:0];
               default: ;
            endcase
         end
      end
      results_pending <= expected_pixels.size();
      failures        <= fail_count;
   end

endmodule

// ===== dv/sprite_scale_compositor_core_tb.sv =====
// Top of the sprite scale compositor regression: clock, reset, stimulus,
// response flow control and the verdict.
// Depends on ssc_pkg, ssc_if.sv, the core and sprite_pixel_checker.
module sprite_scale_compositor_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ssc_pkg::*;

   localparam int DRAW_W      = (SPRITE_WIDTH * SCALE_NUM + SCALE_DEN / 2) / SCALE_DEN;
   localparam int DRAW_H      = (SPRITE_HEIGHT * SCALE_NUM + SCALE_DEN / 2) / SCALE_DEN;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 110;
   localparam int HOLD_CYCLES = 300;

   logic clock;
   logic reset;
   int   results_pending;
   int   failures;

   ssc_req_if req_ch ();
   ssc_rsp_if rsp_ch ();
   ssc_csr_if csr_ch ();

   sprite_scale_compositor_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   sprite_pixel_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .rsp_ch          (rsp_ch),
      .csr_ch          (csr_ch),
      .results_pending (results_pending),
      .failures        (failures)
   );

   // Stimulus-side view of the registers and of which store entries hold data.
   int  cfg_cx = int'(CENTER_RESET);
   int  cfg_cy = int'(CENTER_RESET);
   int  cfg_fw = int'(FRAME_RESET);
   int  cfg_fh = int'(FRAME_RESET);
   bit  sprite_written [STORE_DEPTH];
   int  req_idle_pct  = 0;
   int  rsp_stall_pct = 0;
   bit  hold_armed    = 1'b0;
   bit  hold_taken    = 1'b0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Response flow control: random stalls, plus one long hold-off on request.
   initial begin : rsp_flow
      int hold_left;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_armed && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   function automatic int box_origin(input int center, input int span, input int draw);
      int c;
      c = center;
      if (c < draw / 2) c = draw / 2;
      else if (c > span - draw / 2) c = span - draw / 2;
      return c - draw / 2;
   endfunction

   // Tells whether a render at (x, y) reads the store, and at which entry.
   function automatic bit reads_store(input int x, input int y, output int addr);
      int dx;
      int dy;
      int sx;
      int sy;
      addr = 0;
      dx = x - box_origin(cfg_cx, SCREEN_WIDTH, DRAW_W);
      dy = y - box_origin(cfg_cy, SCREEN_HEIGHT, DRAW_H);
      if (dx < 0 || dx >= DRAW_W || dy < 0 || dy >= DRAW_H) return 1'b0;
      sx = dx * SCALE_DEN / SCALE_NUM;
      sy = dy * SCALE_DEN / SCALE_NUM;
      if (sx >= cfg_fw || sy >= cfg_fh) return 1'b0;
      addr = (sy * cfg_fw + sx) % STORE_DEPTH;
      return 1'b1;
   endfunction

   // Mostly near the box, edges included; sometimes anywhere on screen.
   function automatic int pick_coord(input int center, input int span, input int draw);
      int v;
      v = box_origin(center, span, draw) - 8 + int'($urandom_range(draw + 15));
      if ($urandom_range(99) < 20 || v < 0 || v >= span) v = $urandom_range(span - 1);
      return v;
   endfunction

   task automatic send_item(input logic m, input logic [PIXEL_W-1:0] x,
                            input logic [PIXEL_W-1:0] y, input logic [ADDR_W-1:0] addr,
                            input logic [COLOR_W-1:0] value);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.mode         <= m;
      req_ch.pixel_x      <= x;
      req_ch.pixel_y      <= y;
      req_ch.sprite_addr  <= addr;
      req_ch.sprite_value <= value;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Pixel fields of a write are noise that the block must ignore.
   task automatic write_pixel(input logic [ADDR_W-1:0] addr, input logic [COLOR_W-1:0] value);
      send_item(MODE_WRITE, PIXEL_W'($urandom), PIXEL_W'($urandom), addr, value);
      sprite_written[addr] = 1'b1;
   endtask

   // A render that would read an empty entry is preceded by a write to it.
   task automatic render_at(input int x, input int y);
      int addr;
      if (reads_store(x, y, addr) && !sprite_written[addr])
         write_pixel(ADDR_W'(addr), COLOR_W'($urandom));
      send_item(MODE_RENDER, PIXEL_W'(x), PIXEL_W'(y), ADDR_W'($urandom), COLOR_W'($urandom));
   endtask

   // The caller drops csr_ch.valid after the last write of a burst.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         REG_CENTER_X:     cfg_cx = value;
         REG_CENTER_Y:     cfg_cy = value;
         REG_FRAME_WIDTH:  cfg_fw = value;
         REG_FRAME_HEIGHT: cfg_fh = value;
         default: ;
      endcase
   endtask

   // Stop sending and wait for every pending pixel, then for writes to retire.
   task automatic settle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (results_pending != 0);
      repeat (12) @(posedge clock);
   endtask

   task automatic load_config(input int cx, input int cy, input int fw, input int fh,
                              input int bg);
      settle();
      write_reg(REG_CENTER_X, cx);
      write_reg(REG_CENTER_Y, cy);
      write_reg(REG_FRAME_WIDTH, fw);
      write_reg(REG_FRAME_HEIGHT, fh);
      write_reg(REG_BACKGROUND, bg);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic random_config();
      logic signed [CENTER_W-1:0] raw_x;
      logic signed [CENTER_W-1:0] raw_y;
      int                         cx;
      int                         cy;
      int                         fw;
      int                         fh;
      raw_x = CENTER_W'($urandom);
      raw_y = CENTER_W'($urandom);
      if ($urandom_range(99) < 15) cx = int'(raw_x);
      else cx = $urandom_range(SCREEN_WIDTH - 1);
      if ($urandom_range(99) < 15) cy = int'(raw_y);
      else cy = $urandom_range(SCREEN_HEIGHT - 1);
      if ($urandom_range(9) == 0) fw = $urandom_range(SPRITE_WIDTH);
      else fw = $urandom_range(SPRITE_WIDTH, SPRITE_WIDTH / 2);
      if ($urandom_range(9) == 0) fh = $urandom_range(SPRITE_HEIGHT);
      else fh = $urandom_range(SPRITE_HEIGHT, SPRITE_HEIGHT / 2);
      load_config(cx, cy, fw, fh, $urandom_range(16'hFFFF));
   endtask

   task automatic random_item();
      if ($urandom_range(99) < 25)
         write_pixel(ADDR_W'($urandom), COLOR_W'($urandom));
      else
         render_at(pick_coord(cfg_cx, SCREEN_WIDTH, DRAW_W),
                   pick_coord(cfg_cy, SCREEN_HEIGHT, DRAW_H));
   endtask

   initial begin : stimulus
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.mode         <= MODE_WRITE;
      req_ch.pixel_x      <= '0;
      req_ch.pixel_y      <= '0;
      req_ch.sprite_addr  <= '0;
      req_ch.sprite_value <= '0;
      csr_ch.valid        <= 1'b0;
      csr_ch.index        <= REG_CENTER_X;
      csr_ch.data         <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset geometry: box spans 160..351 in both directions.
      write_pixel(ADDR_W'(0), 16'hFFFF);
      write_pixel(ADDR_W'(STORE_DEPTH - 1), 16'h0000);
      render_at(160, 160);
      render_at(351, 351);
      render_at(161, 161);
      render_at(159, 160);
      render_at(160, 159);
      render_at(352, 351);
      render_at(351, 352);
      render_at(0, 0);
      render_at(511, 511);

      // Requested centres far off screen are clamped; a zero-width frame is all background.
      load_config(-2048, 2047, 0, 128, 16'hFFFF);
      render_at(0, 320);
      render_at(191, 511);
      render_at(192, 511);
      load_config(2047, -2048, 128, 0, 16'h0000);
      render_at(511, 0);
      render_at(319, 0);

      // Centres one past the clamp limits and a one-pixel frame: sources in and just outside the frame.
      load_config(95, 417, 1, 1, 16'h5AA5);
      render_at(0, 320);
      render_at(1, 321);
      render_at(2, 320);
      render_at(0, 322);

      // Random phases, each with its own setting and one of four idling patterns.
      for (int p = 0; p < PHASES; p++) begin
         if (p == 0)
            load_config(int'(CENTER_RESET), int'(CENTER_RESET), int'(FRAME_RESET),
                        int'(FRAME_RESET), int'(BACKGROUND_RESET));
         else if (p == 1)
            load_config(2047, 0, 128, 128, 16'hFFFF);
         else
            random_config();
         case (p % 4)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 84; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 84; end
            default: begin req_idle_pct = 24; rsp_stall_pct = 24; end
         endcase
         repeat (PHASE_ITEMS) random_item();
      end

      // Long response hold-off while requests keep coming, so the pipeline backs up.
      settle();
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      hold_armed    = 1'b1;
      repeat (40)
         render_at(pick_coord(cfg_cx, SCREEN_WIDTH, DRAW_W),
                   pick_coord(cfg_cy, SCREEN_HEIGHT, DRAW_H));

      settle();
      if (failures == 0)
         $display("sprite_scale_compositor_core regression: pass");
      else
         $display("sprite_scale_compositor_core regression: fail");
      $finish;
   end

   // Hard stop if the block hangs.
   initial begin : watchdog
      #5_000_000;
      $display("sprite_scale_compositor_core regression: fail");
      $finish;
   end

endmodule
